[rtl/core/plba_pkg.sv]
`default_nettype none
package plba_pkg;

  localparam int unsigned MAX_PAGES_DEF   = 64;
  localparam int unsigned LARGE_SLOTS_DEF = 8;
  localparam int unsigned FENCE_BITS_DEF  = 64;

  localparam int unsigned PSIZE_W   = 25;
  localparam int unsigned SIZE_W    = 32;
  localparam int unsigned ALIGN_W   = 5;
  localparam int unsigned FENCE_W   = 64;
  localparam int unsigned PID_W     = 6;
  localparam int unsigned STATUS_W  = 2;
  localparam logic [PSIZE_W-1:0] PAGE_SIZE_RESET = 25'd65536;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_POOL_EMPTY = 2'd1,
    ST_LARGE_FULL = 2'd2
  } status_t;

  typedef enum logic {
    CMD_ALLOC   = 1'b0,
    CMD_CLEANUP = 1'b1
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_LARGE,
    S_DRAIN,
    S_PICK,
    S_RETIRE,
    S_DELFREE,
    S_DELQ,
    S_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic decide;
    logic large_step;
    logic drain_step;
    logic pick;
    logic retire_step;
    logic delfree_step;
    logic delq_step;
    logic finish_cleanup;
    logic out_load;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_cleanup;
    logic is_large;
    logic need_page;
    logic large_done;
    logic drain_done;
    logic retire_done;
    logic delfree_done;
    logic delq_done;
  } dp_stat_t;

endpackage
`default_nettype wire

[rtl/core/plba_ctrl.sv]
`default_nettype none
module plba_ctrl
  import plba_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  output dp_cmd_t       cmd,
  input  wire dp_stat_t stat
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // State and output-holding registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // Next state and commands.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    in_ready      = 1'b0;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        if (stat.is_cleanup)     state_nxt = S_RETIRE;
        else if (stat.is_large)  state_nxt = S_LARGE;
        else if (stat.need_page) state_nxt = S_DRAIN;
        else                     state_nxt = S_OUT;
      end
      S_LARGE: begin
        cmd.large_step = 1'b1;
        if (stat.large_done) state_nxt = S_OUT;
      end
      S_DRAIN: begin
        cmd.drain_step = 1'b1;
        if (stat.drain_done) state_nxt = S_PICK;
      end
      S_PICK: begin
        cmd.pick  = 1'b1;
        state_nxt = S_OUT;
      end
      S_RETIRE: begin
        cmd.retire_step = 1'b1;
        if (stat.retire_done) state_nxt = S_DELFREE;
      end
      S_DELFREE: begin
        cmd.delfree_step = 1'b1;
        if (stat.delfree_done) state_nxt = S_DELQ;
      end
      S_DELQ: begin
        cmd.delq_step = 1'b1;
        if (stat.delq_done) begin
          cmd.finish_cleanup = 1'b1;
          state_nxt          = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

[rtl/core/plba_dp.sv]
`default_nettype none
module plba_dp
  import plba_pkg::*;
#(
  parameter int unsigned MAX_PAGES   = MAX_PAGES_DEF,
  parameter int unsigned LARGE_SLOTS = LARGE_SLOTS_DEF,
  parameter int unsigned FENCE_BITS  = FENCE_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [PSIZE_W-1:0] cfg_wdata,
  input  wire logic               in_command,
  input  wire logic [SIZE_W-1:0]  in_size_bytes,
  input  wire logic [ALIGN_W-1:0] in_align_log2,
  input  wire logic [FENCE_W-1:0] in_fence_value,
  input  wire logic [FENCE_W-1:0] in_completed_fence,
  input  wire dp_cmd_t            cmd,
  output dp_stat_t                stat,
  output logic [PID_W-1:0]        out_page_id,
  output logic [PSIZE_W-1:0]      out_offset,
  output logic [SIZE_W-1:0]       out_aligned_size,
  output logic                    out_is_large,
  output logic                    out_fresh_page,
  output logic [STATUS_W-1:0]     out_status
);

  localparam int unsigned PW  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int unsigned CW  = $clog2(MAX_PAGES + 1);
  localparam int unsigned LW  = (LARGE_SLOTS > 1) ? $clog2(LARGE_SLOTS) : 1;
  localparam int unsigned LCW = $clog2(LARGE_SLOTS + 1);
  localparam int unsigned OW  = PSIZE_W + 1;

  // Configuration.
  logic [PSIZE_W-1:0] page_size_r;
  always_ff @(posedge clk) begin
    if (!rst_n)      page_size_r <= PAGE_SIZE_RESET;
    else if (cfg_we) page_size_r <= cfg_wdata;
  end

  // Captured request.
  logic                  cmd_r;
  logic [SIZE_W:0]       aligned_r;
  logic [SIZE_W-1:0]     amask_r;
  logic [FENCE_BITS-1:0] tag_r, done_r;

  logic [SIZE_W-1:0] amask_c;
  logic [SIZE_W:0]   sum_c;
  always_comb begin
    amask_c = (SIZE_W'(1) << in_align_log2) - SIZE_W'(1);
    sum_c   = {1'b0, in_size_bytes} + {1'b0, amask_c};
  end

  // Round the size up; a carry out of the size word lands in the top bit.
  logic [SIZE_W:0] aligned_c;
  assign aligned_c = sum_c & ~{1'b0, amask_c};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r     <= in_command;
      aligned_r <= aligned_c;
      amask_r   <= amask_c;
      tag_r     <= in_fence_value[FENCE_BITS-1:0];
      done_r    <= in_completed_fence[FENCE_BITS-1:0];
    end
  end

  // Allocator state.
  logic [PW-1:0]      cur_page_r;
  logic               cur_valid_r;
  logic [OW-1:0]      cur_off_r;
  logic [CW-1:0]      used_cnt_r, pages_created_r;
  logic [PW-1:0]      ret_head_r, av_head_r;
  logic [CW-1:0]      ret_cnt_r, av_cnt_r;
  logic [LCW-1:0]     large_cnt_r, del_cnt_r;
  logic [LW-1:0]      del_head_r;
  logic [LARGE_SLOTS-1:0] busy_r;
  logic [CW-1:0]      idx_r;

  logic [PW-1:0]         used_mem [MAX_PAGES];
  logic [PW-1:0]         ret_page_mem [MAX_PAGES];
  logic [FENCE_BITS-1:0] ret_fence_mem [MAX_PAGES];
  logic [PW-1:0]         av_mem [MAX_PAGES];
  logic [LW-1:0]         large_list_r [LARGE_SLOTS];
  logic [LW-1:0]         del_slot_r [LARGE_SLOTS];
  logic [FENCE_BITS-1:0] del_fence_r [LARGE_SLOTS];

  // Offset alignment and fit check.
  logic [OW+1:0] cur_al_c, end_c;
  logic          need_c, large_c;
  always_comb begin
    cur_al_c = ({2'b0, cur_off_r} + {2'b0, amask_r[OW-1:0]})
               & ~{2'b0, amask_r[OW-1:0]};
    if (amask_r[SIZE_W-1:OW] != '0 && cur_off_r != '0) cur_al_c = {2'b10, {OW{1'b0}}};
    end_c    = cur_al_c + aligned_r[OW+1:0];
    large_c  = aligned_r > {{(SIZE_W+1-PSIZE_W){1'b0}}, page_size_r};
    need_c   = !cur_valid_r || (end_c > {{(OW+2-PSIZE_W){1'b0}}, page_size_r});
  end

  // Registered memory reads for sequential walks.
  logic [PW-1:0]         used_rd_r, ret_page_rd_r, av_rd_r;
  logic [FENCE_BITS-1:0] ret_fence_rd_r;
  logic                  rd_ok_r;

  // Result register contents.
  logic [PID_W-1:0]   pid_r;
  logic [PSIZE_W-1:0] off_r;
  logic               large_r, fresh_r;
  status_t            st_r;

  // Large-slot search position (first free bit).
  logic [LW-1:0] free_idx_c;
  logic          free_any_c;
  always_comb begin
    free_idx_c = '0;
    free_any_c = 1'b0;
    for (int i = LARGE_SLOTS - 1; i >= 0; i--) begin
      if (!busy_r[i]) begin
        free_idx_c = LW'(i);
        free_any_c = 1'b1;
      end
    end
  end

  logic [PW-1:0] ret_tail_c, av_tail_c;
  logic [LW-1:0] del_tail_c;
  assign ret_tail_c = PW'((CW'(ret_head_r) + ret_cnt_r) % MAX_PAGES);
  assign av_tail_c  = PW'((CW'(av_head_r) + av_cnt_r) % MAX_PAGES);
  assign del_tail_c = LW'((LCW'(del_head_r) + del_cnt_r) % LARGE_SLOTS);

  logic drain_ok_c;
  assign drain_ok_c = rd_ok_r && ret_cnt_r != '0 && ret_fence_rd_r <= done_r
                      && av_cnt_r < CW'(MAX_PAGES);

  // Status to the controller.
  always_comb begin
    stat.is_cleanup   = cmd_r;
    stat.is_large     = large_c;
    stat.need_page    = need_c;
    stat.large_done   = 1'b1;
    stat.drain_done   = rd_ok_r && !drain_ok_c;
    stat.retire_done  = rd_ok_r && idx_r >= used_cnt_r;
    stat.delfree_done = del_cnt_r == '0 || del_fence_r[del_head_r] > done_r;
    stat.delq_done    = idx_r >= CW'(large_cnt_r);
  end

  // Main datapath sequencing.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_page_r      <= '0;
      cur_valid_r     <= 1'b0;
      cur_off_r       <= '0;
      used_cnt_r      <= '0;
      pages_created_r <= '0;
      ret_head_r      <= '0;
      ret_cnt_r       <= '0;
      av_head_r       <= '0;
      av_cnt_r        <= '0;
      large_cnt_r     <= '0;
      del_cnt_r       <= '0;
      del_head_r      <= '0;
      busy_r          <= '0;
      idx_r           <= '0;
      rd_ok_r         <= 1'b0;
    end else begin
      ret_page_rd_r  <= ret_page_mem[ret_head_r];
      ret_fence_rd_r <= ret_fence_mem[ret_head_r];
      av_rd_r        <= av_mem[av_head_r];
      used_rd_r      <= used_mem[PW'(idx_r)];
      rd_ok_r        <= 1'b0;

      if (cmd.decide) begin
        idx_r   <= '0;
        pid_r   <= '0;
        off_r   <= '0;
        large_r <= 1'b0;
        fresh_r <= 1'b0;
        st_r    <= ST_OK;
        if (cmd_r) begin
          // Push the current page onto the used list first.
          if (cur_valid_r && used_cnt_r < CW'(MAX_PAGES)) begin
            used_mem[PW'(used_cnt_r)] <= cur_page_r;
            used_cnt_r <= used_cnt_r + 1'b1;
          end
          cur_valid_r <= 1'b0;
          cur_off_r   <= '0;
        end else if (!large_c && !need_c) begin
          pid_r     <= PID_W'(cur_page_r);
          off_r     <= cur_al_c[PSIZE_W-1:0];
          cur_off_r <= OW'(end_c);
        end
      end

      if (cmd.large_step) begin
        large_r <= 1'b1;
        if (free_any_c && large_cnt_r < LCW'(LARGE_SLOTS)) begin
          busy_r[free_idx_c]        <= 1'b1;
          large_list_r[LW'(large_cnt_r)] <= free_idx_c;
          large_cnt_r               <= large_cnt_r + 1'b1;
          pid_r                     <= PID_W'(free_idx_c);
        end else begin
          st_r <= ST_LARGE_FULL;
        end
      end

      // Drain: read head, then move if complete.
      if (cmd.drain_step) begin
        rd_ok_r <= 1'b1;
        if (drain_ok_c) begin
          av_mem[av_tail_c] <= ret_page_rd_r;
          av_cnt_r          <= av_cnt_r + 1'b1;
          ret_head_r        <= PW'((CW'(ret_head_r) + 1'b1) % MAX_PAGES);
          ret_cnt_r         <= ret_cnt_r - 1'b1;
          rd_ok_r           <= 1'b0;
        end
      end

      if (cmd.pick) begin
        if (av_cnt_r != '0 || pages_created_r < CW'(MAX_PAGES)) begin
          if (av_cnt_r != '0) begin
            cur_page_r <= av_rd_r;
            pid_r      <= PID_W'(av_rd_r);
            av_head_r  <= PW'((CW'(av_head_r) + 1'b1) % MAX_PAGES);
            av_cnt_r   <= av_cnt_r - 1'b1;
          end else begin
            cur_page_r      <= PW'(pages_created_r);
            pid_r           <= PID_W'(pages_created_r);
            pages_created_r <= pages_created_r + 1'b1;
            fresh_r         <= 1'b1;
          end
          if (cur_valid_r && used_cnt_r < CW'(MAX_PAGES)) begin
            used_mem[PW'(used_cnt_r)] <= cur_page_r;
            used_cnt_r <= used_cnt_r + 1'b1;
          end
          cur_valid_r <= 1'b1;
          cur_off_r   <= OW'(aligned_r);
        end else begin
          st_r <= ST_POOL_EMPTY;
        end
      end

      // Retire walk: each used entry is read, then pushed onto the retired FIFO.
      if (cmd.retire_step) begin
        if (!rd_ok_r) begin
          rd_ok_r <= 1'b1;
        end else if (idx_r < used_cnt_r) begin
          if (ret_cnt_r < CW'(MAX_PAGES)) begin
            ret_page_mem[ret_tail_c]  <= used_rd_r;
            ret_fence_mem[ret_tail_c] <= tag_r;
            ret_cnt_r                 <= ret_cnt_r + 1'b1;
          end
          idx_r <= idx_r + 1'b1;
        end else begin
          used_cnt_r <= '0;
          idx_r      <= '0;
        end
      end

      if (cmd.delfree_step && !stat.delfree_done) begin
        busy_r[del_slot_r[del_head_r]] <= 1'b0;
        del_head_r <= LW'((LCW'(del_head_r) + 1'b1) % LARGE_SLOTS);
        del_cnt_r  <= del_cnt_r - 1'b1;
      end

      if (cmd.delq_step && !stat.delq_done) begin
        if (del_cnt_r < LCW'(LARGE_SLOTS)) begin
          del_slot_r[del_tail_c]  <= large_list_r[LW'(idx_r)];
          del_fence_r[del_tail_c] <= tag_r;
          del_cnt_r               <= del_cnt_r + 1'b1;
        end
        idx_r <= idx_r + 1'b1;
      end

      if (cmd.finish_cleanup) large_cnt_r <= '0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_page_id      <= cmd_r ? '0 : pid_r;
      out_offset       <= cmd_r ? '0 : off_r;
      out_aligned_size <= cmd_r ? '0 : (aligned_r[SIZE_W] ? '1 : aligned_r[SIZE_W-1:0]);
      out_is_large     <= cmd_r ? 1'b0 : large_r;
      out_fresh_page   <= cmd_r ? 1'b0 : fresh_r;
      out_status       <= cmd_r ? ST_OK : st_r;
    end
  end

endmodule
`default_nettype wire

[rtl/core/paged_linear_bump_allocator_core.sv]
`default_nettype none
// Sequencing: an allocate that fits goes from decide straight to the output; a large one
// takes a large slot first, and one that needs a page drains completed retired pages, then picks one.
// Cleanup retires the used pages, frees large slots whose fence is done, then queues large slots.
// One item at a time: input is ready again only after the result is loaded into the output
// register, and that load waits while an earlier result has not been taken.
// Reset: synchronous active-low rst_n empties every list and FIFO at once.
module paged_linear_bump_allocator_core
  import plba_pkg::*;
#(
  parameter int unsigned MAX_PAGES   = MAX_PAGES_DEF,
  parameter int unsigned LARGE_SLOTS = LARGE_SLOTS_DEF,
  parameter int unsigned FENCE_BITS  = FENCE_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [PSIZE_W-1:0] cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_command,
  input  wire logic [SIZE_W-1:0]  in_size_bytes,
  input  wire logic [ALIGN_W-1:0] in_align_log2,
  input  wire logic [FENCE_W-1:0] in_fence_value,
  input  wire logic [FENCE_W-1:0] in_completed_fence,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [PID_W-1:0]        out_page_id,
  output logic [PSIZE_W-1:0]      out_offset,
  output logic [SIZE_W-1:0]       out_aligned_size,
  output logic                    out_is_large,
  output logic                    out_fresh_page,
  output logic [STATUS_W-1:0]     out_status
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer.
  plba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Allocator state and arithmetic.
  plba_dp #(
    .MAX_PAGES   (MAX_PAGES),
    .LARGE_SLOTS (LARGE_SLOTS),
    .FENCE_BITS  (FENCE_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_command         (in_command),
    .in_size_bytes      (in_size_bytes),
    .in_align_log2      (in_align_log2),
    .in_fence_value     (in_fence_value),
    .in_completed_fence (in_completed_fence),
    .cmd                (cmd),
    .stat               (stat),
    .out_page_id        (out_page_id),
    .out_offset         (out_offset),
    .out_aligned_size   (out_aligned_size),
    .out_is_large       (out_is_large),
    .out_fresh_page     (out_fresh_page),
    .out_status         (out_status)
  );

endmodule
`default_nettype wire

[bench/plba_checker.sv]
`timescale 1ns / 100ps
module plba_checker
  import plba_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [PSIZE_W-1:0] cfg_wdata,
  input  wire logic               in_valid,
  input  wire logic               in_ready,
  input  wire logic               in_command,
  input  wire logic [SIZE_W-1:0]  in_size_bytes,
  input  wire logic [ALIGN_W-1:0] in_align_log2,
  input  wire logic [FENCE_W-1:0] in_fence_value,
  input  wire logic [FENCE_W-1:0] in_completed_fence,
  input  wire logic               out_valid,
  input  wire logic               out_ready,
  input  wire logic [PID_W-1:0]   out_page_id,
  input  wire logic [PSIZE_W-1:0] out_offset,
  input  wire logic [SIZE_W-1:0]  out_aligned_size,
  input  wire logic               out_is_large,
  input  wire logic               out_fresh_page,
  input  wire logic [STATUS_W-1:0] out_status,
  output int                      fail_count,
  output int                      pending_count,
  output int                      grant_count
);

  typedef struct packed {
    logic [PID_W-1:0]   page_id;
    logic [PSIZE_W-1:0] offset;
    logic [SIZE_W-1:0]  aligned_size;
    logic               is_large;
    logic               fresh_page;
    status_t            status;
  } grant_t;

  grant_t grant_q[$];

  // Shadow copy of the allocator state.
  logic [PSIZE_W-1:0] page_bytes;
  logic [5:0]  cur_page;
  logic        cur_valid;
  logic [63:0] cur_off;
  logic [5:0]  used_pages[$];
  logic [5:0]  retired_pid[$];
  logic [63:0] retired_tag[$];
  logic [5:0]  free_pages[$];
  int          pages_made;
  logic [2:0]  period_large[$];
  logic [2:0]  doomed_slot[$];
  logic [63:0] doomed_tag[$];
  logic [7:0]  slot_busy;

  function automatic grant_t allocate(logic cmd, logic [31:0] size, logic [4:0] al,
                                      logic [63:0] tag, logic [63:0] done);
    grant_t g;
    logic [63:0] amask, rounded, cur;
    logic [5:0] np;
    logic got, need;
    g = '0;
    if (cmd == CMD_CLEANUP) begin
      if (cur_valid && used_pages.size() < 64) used_pages = {used_pages, cur_page};
      cur_valid = 1'b0;
      cur_off = 0;
      foreach (used_pages[i]) begin
        if (retired_pid.size() < 64) begin
          retired_pid = {retired_pid, used_pages[i]};
          retired_tag = {retired_tag, tag};
        end
      end
      used_pages.delete();
      while (doomed_slot.size() > 0 && doomed_tag[0] <= done) begin
        slot_busy[doomed_slot[0]] = 1'b0;
        void'(doomed_slot.pop_front());
        void'(doomed_tag.pop_front());
      end
      foreach (period_large[i]) begin
        if (doomed_slot.size() < 8) begin
          doomed_slot = {doomed_slot, period_large[i]};
          doomed_tag = {doomed_tag, tag};
        end
      end
      period_large.delete();
      return g;
    end
    amask = (64'd1 << al) - 64'd1;
    rounded = ({32'd0, size} + amask) & ~amask;
    g.aligned_size = (rounded > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : rounded[31:0];
    g.status = ST_OK;
    if (rounded > {39'd0, page_bytes}) begin
      g.is_large = 1'b1;
      g.status = ST_LARGE_FULL;
      for (int i = 0; i < 8; i++) begin
        if (!slot_busy[i] && period_large.size() < 8) begin
          slot_busy[i] = 1'b1;
          period_large = {period_large, 3'(i)};
          g.page_id = 6'(i);
          g.status = ST_OK;
          break;
        end
      end
      return g;
    end
    cur = (cur_off + amask) & ~amask;
    need = !cur_valid || (cur + rounded > {39'd0, page_bytes});
    g.offset = cur[24:0];
    g.page_id = cur_page;
    if (need) begin
      got = 1'b0;
      np = '0;
      while (retired_pid.size() > 0 && retired_tag[0] <= done && free_pages.size() < 64) begin
        free_pages = {free_pages, retired_pid.pop_front()};
        void'(retired_tag.pop_front());
      end
      if (free_pages.size() > 0) begin
        np = free_pages.pop_front();
        got = 1'b1;
      end else if (pages_made < 64) begin
        np = 6'(pages_made);
        pages_made++;
        g.fresh_page = 1'b1;
        got = 1'b1;
      end
      if (!got) begin
        g.status = ST_POOL_EMPTY;
        g.page_id = '0;
        g.offset = '0;
        cur = 0;
      end else begin
        if (cur_valid && used_pages.size() < 64) used_pages = {used_pages, cur_page};
        cur_page = np;
        cur_valid = 1'b1;
        g.page_id = np;
        g.offset = '0;
        cur = 0;
      end
    end
    if (g.status == ST_OK) cur_off = cur + rounded;
    return g;
  endfunction

  // Predict on every accepted input transfer and compare every output transfer.
  always @(posedge clk) begin
    grant_t seen, want;
    if (!rst_n) begin
      page_bytes <= PAGE_SIZE_RESET;
      cur_page = '0; cur_valid = 1'b0; cur_off = 0;
      used_pages.delete(); retired_pid.delete(); retired_tag.delete();
      free_pages.delete(); pages_made = 0; period_large.delete();
      doomed_slot.delete(); doomed_tag.delete(); slot_busy = '0;
      grant_q.delete();
      fail_count <= 0;
      grant_count <= 0;
    end else begin
      if (cfg_we) page_bytes <= cfg_wdata;
      if (in_valid && in_ready)
        grant_q = {grant_q, allocate(in_command, in_size_bytes, in_align_log2,
                                     in_fence_value, in_completed_fence)};
      if (out_valid && out_ready) begin
        grant_count <= grant_count + 1;
        seen = '{out_page_id, out_offset, out_aligned_size, out_is_large,
                 out_fresh_page, status_t'(out_status)};
        if (grant_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result transfer %p", seen);
          fail_count <= fail_count + 1;
        end else begin
          want = grant_q.pop_front();
          if (seen !== want) begin
            if (fail_count < 10) $display("mismatch: expected %p, got %p", want, seen);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending_count <= grant_q.size();
  end

endmodule

[bench/tb_paged_linear_bump_allocator_core.sv]
`timescale 1ns / 100ps
module tb_paged_linear_bump_allocator_core;
  import plba_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [PSIZE_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_command = 1'b0;
  logic [SIZE_W-1:0] in_size_bytes = '0;
  logic [ALIGN_W-1:0] in_align_log2 = '0;
  logic [FENCE_W-1:0] in_fence_value = '0;
  logic [FENCE_W-1:0] in_completed_fence = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [PID_W-1:0] out_page_id;
  logic [PSIZE_W-1:0] out_offset;
  logic [SIZE_W-1:0] out_aligned_size;
  logic out_is_large, out_fresh_page;
  logic [STATUS_W-1:0] out_status;
  int fail_count, pending_count, grant_count;
  int idle_cycles = 0;
  int hold_off = 0;
  bit no_gaps = 1'b0;
  int sent = 0;
  logic [63:0] fence_now = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  paged_linear_bump_allocator_core dut (.*);
  plba_checker chk (.*);

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver: random stalls, or a long hold-off when requested.
  initial begin
    int w;
    forever begin
      @(posedge clk);
      if (hold_off > 0) begin
        out_ready <= 1'b0;
        repeat (hold_off) @(posedge clk);
        hold_off = 0;
      end
      w = no_gaps ? 0 : $urandom_range(0, 10);
      if (w > 0) begin
        out_ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      out_ready <= 1'b0;
    end
  end

  // Within send, valid drops only when a gap is drawn, so back-to-back items keep it high.
  task automatic send(logic cmd, logic [31:0] size, logic [4:0] al,
                      logic [63:0] tag, logic [63:0] done);
    int w;
    w = no_gaps ? 0 : $urandom_range(0, 10);
    if (w > 0) begin
      in_valid <= 1'b0;
      repeat (w) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_size_bytes <= size;
    in_align_log2 <= al;
    in_fence_value <= tag;
    in_completed_fence <= done;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic drain_out();
    in_valid <= 1'b0;
    while (pending_count != 0 || chk.grant_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_page_size(logic [PSIZE_W-1:0] v);
    drain_out();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // One random item: mostly small allocations, occasional cleanup with advancing fences.
  task automatic random_item(int phase_bytes);
    logic [31:0] sz;
    logic [63:0] t;
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      fence_now = fence_now + $urandom_range(1, 3);
      t = ($urandom_range(0, 19) == 0) ? {$urandom, $urandom} : fence_now;
      send(CMD_CLEANUP, $urandom, 5'($urandom), t,
           ($urandom_range(0, 9) == 0) ? {$urandom, $urandom} :
           fence_now - $urandom_range(0, 3));
    end else begin
      if (r < 14) sz = $urandom;
      else if (r < 20) sz = phase_bytes + $urandom_range(0, 64);
      else sz = $urandom_range(0, phase_bytes / 3);
      send(CMD_ALLOC, sz, ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                                      : 5'($urandom_range(0, 6)),
           {$urandom, $urandom},
           ($urandom_range(0, 4) == 0) ? {$urandom, $urandom} : fence_now);
    end
  endtask

  initial begin
    int sizes[4];
    sizes = '{256, 1000, 4096, 16777216};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes and special cases at the reset page size.
    send(CMD_ALLOC, 32'd0, 5'd0, '0, '0);
    send(CMD_ALLOC, 32'd1, 5'd16, '0, '0);
    send(CMD_ALLOC, 32'd65536, 5'd0, '0, '0);
    send(CMD_ALLOC, 32'd65537, 5'd0, '0, '0);
    send(CMD_ALLOC, 32'hFFFF_0000, 5'd16, '1, '1);
    send(CMD_ALLOC, 32'hFFFF_FFFF, 5'd31, '0, '0);
    for (int i = 0; i < 8; i++) send(CMD_ALLOC, 32'd70000, 5'd3, '0, '0);
    send(CMD_ALLOC, 32'd40000, 5'd4, '0, '0);
    send(CMD_ALLOC, 32'd40000, 5'd4, '0, '0);
    send(CMD_CLEANUP, 32'hFFFF_FFFF, 5'd31, 64'd5, 64'd0);
    send(CMD_CLEANUP, '0, '0, '1, 64'd5);
    send(CMD_ALLOC, 32'd100, 5'd2, '0, 64'd5);
    send(CMD_CLEANUP, '0, '0, 64'd6, '1);
    send(CMD_ALLOC, 32'd65536, 5'd0, '1, '1);
    fence_now = 10;

    // Pool exhaustion at the smallest page size.
    write_page_size(25'd256);
    for (int i = 0; i < 70; i++) send(CMD_ALLOC, 32'd200, 5'd0, '0, '0);
    send(CMD_CLEANUP, '0, '0, 64'd11, 64'd10);

    // Long receiver hold-off while items keep coming.
    hold_off = 400;
    no_gaps = 1'b1;
    for (int i = 0; i < 20; i++) random_item(256);
    no_gaps = 1'b0;

    // Random phases through several page sizes, odd ones included.
    for (int p = 0; p < 6; p++) begin
      int pb;
      pb = (p < 4) ? sizes[p] : $urandom_range(256, 100000);
      write_page_size(25'(pb));
      if (p == 3) write_page_size(25'h1FF_FFFF);
      for (int i = 0; i < 200; i++) random_item(pb > 70000 ? 70000 : pb);
      if (p == 2) drain_out();
    end
    drain_out();

    $display("covered %0d transfers sent and %0d results checked over", sent, grant_count);
    $display("several page sizes, pool and large-slot exhaustion and fence recycling");
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
